### rtl/rtia_pkg.sv
// Shared types and constants for the radial table interpolator.
// Used by rtia_sqrt, rtia_lerp and the top level; depends on nothing.
package rtia_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_ADD  = 2'd1,
    ACT_SUB  = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  localparam logic [1:0] CFG_ENTRY_COUNT = 2'd0;
  localparam logic [1:0] CFG_INV_STEP    = 2'd1;

  // Item fields that ride along the radius pipeline.
  typedef struct packed {
    action_e     action;
    logic [11:0] entry_index;
    logic [31:0] load_real;
    logic [31:0] load_imag;
    logic [47:0] acc_re;
    logic [47:0] acc_im;
  } meta_t;

  // Control and accumulators that ride along the interpolation stages.
  typedef struct packed {
    logic        hit;
    logic        apply;
    logic        sub;
    logic [47:0] acc_re;
    logic [47:0] acc_im;
  } side_t;

endpackage

### rtl/rtia_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module rtia_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 4096,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/rtia_sqrt.sv
// Fully pipelined 64-bit integer square root, one result bit per stage.
// Uses meta_t from rtia_pkg to carry item fields alongside.
module rtia_sqrt import rtia_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [63:0] r2_i,
  input  meta_t       meta_i,
  output logic        valid_o,
  output logic [31:0] rad_o,
  output meta_t       meta_o
);

  localparam int unsigned Steps = 32;

  logic        valid_q [Steps];
  logic [63:0] rem_q   [Steps];
  logic [63:0] res_q   [Steps];
  meta_t       meta_q  [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
    logic        v_in;
    logic [63:0] rem_in, res_in, trial, rem_d, res_d;
    meta_t       m_in;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign rem_in = r2_i;
      assign res_in = '0;
      assign m_in   = meta_i;
    end else begin : g_next
      assign v_in   = valid_q[k-1];
      assign rem_in = rem_q[k-1];
      assign res_in = res_q[k-1];
      assign m_in   = meta_q[k-1];
    end

    always_comb begin
      trial = res_in + Bit;
      if (rem_in >= trial) begin
        rem_d = rem_in - trial;
        res_d = (res_in >> 1) + Bit;
      end else begin
        rem_d = rem_in;
        res_d = res_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        res_q[k]  <= res_d;
        meta_q[k] <= m_in;
      end
    end
  end

  assign valid_o = valid_q[Steps-1];
  assign rad_o   = res_q[Steps-1][31:0];
  assign meta_o  = meta_q[Steps-1];

endmodule

### rtl/rtia_lerp.sv
// Four-stage linear interpolation of a complex entry pair and accumulator update.
// Uses side_t from rtia_pkg.
module rtia_lerp import rtia_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [63:0] lo_i,
  input  logic [63:0] hi_i,
  input  logic [15:0] frac_i,
  input  side_t       side_i,
  output logic        valid_o,
  output logic [47:0] acc_re_o,
  output logic [47:0] acc_im_o,
  output logic        hit_o
);

  logic        valid_q [4];
  side_t       side_q  [4];

  logic [31:0] a_re_q, a_im_q, a2_re_q, a2_im_q;
  logic signed [32:0] d_re_q, d_im_q;
  logic [15:0] frac_q;
  logic signed [49:0] p_re_q, p_im_q;
  logic signed [33:0] v_re_q, v_im_q;
  logic [47:0] acc_re_q, acc_im_q;

  logic signed [32:0] d_re_d, d_im_d;
  logic signed [33:0] v_re_d, v_im_d;
  logic [47:0] ve_re, ve_im;

  assign d_re_d = $signed({hi_i[31], hi_i[31:0]}) - $signed({lo_i[31], lo_i[31:0]});
  assign d_im_d = $signed({hi_i[63], hi_i[63:32]}) - $signed({lo_i[63], lo_i[63:32]});

  // The arithmetic shift of the weighted difference floors toward minus infinity.
  assign v_re_d = $signed({{2{a2_re_q[31]}}, a2_re_q}) + $signed(p_re_q[49:16]);
  assign v_im_d = $signed({{2{a2_im_q[31]}}, a2_im_q}) + $signed(p_im_q[49:16]);

  assign ve_re = {{14{v_re_q[33]}}, v_re_q};
  assign ve_im = {{14{v_im_q[33]}}, v_im_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) valid_q[i] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
      for (int i = 1; i < 4; i++) valid_q[i] <= valid_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int i = 1; i < 4; i++) side_q[i] <= side_q[i-1];
      a_re_q  <= lo_i[31:0];
      a_im_q  <= lo_i[63:32];
      d_re_q  <= d_re_d;
      d_im_q  <= d_im_d;
      frac_q  <= frac_i;
      a2_re_q <= a_re_q;
      a2_im_q <= a_im_q;
      p_re_q  <= d_re_q * $signed({1'b0, frac_q});
      p_im_q  <= d_im_q * $signed({1'b0, frac_q});
      v_re_q  <= v_re_d;
      v_im_q  <= v_im_d;
      if (side_q[2].apply && side_q[2].sub) begin
        acc_re_q <= side_q[2].acc_re - ve_re;
        acc_im_q <= side_q[2].acc_im - ve_im;
      end else if (side_q[2].apply) begin
        acc_re_q <= side_q[2].acc_re + ve_re;
        acc_im_q <= side_q[2].acc_im + ve_im;
      end else begin
        acc_re_q <= side_q[2].acc_re;
        acc_im_q <= side_q[2].acc_im;
      end
    end
  end

  assign valid_o  = valid_q[3];
  assign acc_re_o = acc_re_q;
  assign acc_im_o = acc_im_q;
  assign hit_o    = side_q[3].hit;

endmodule

### rtl/radial_table_interp_accumulate.sv
// Top level of the radial table interpolator with accumulation.
// Depends on rtia_pkg, rtia_ram, rtia_sqrt and rtia_lerp.
//
// The block accepts one transaction every cycle while the skid entry is empty
// and returns one result per transaction, in order: two stages form the
// squared radius, 32 stages of the square-root pipeline produce one radius bit
// each, then come the scale multiply, the table read, four interpolation and
// accumulation stages and the output register. A two-deep output buffer lets
// one more transaction in while a result waits. Table loads travel the same
// pipeline and write at the read stage, so loads and lookups keep their order.
// The table holds no reset value; a lookup of an entry never loaded returns
// unspecified sums. Configuration writes are taken at any time.
module radial_table_interp_accumulate import rtia_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // entry_index[11:0], load_real[43:12], load_imag[75:44], pos_x[107:76],
  // pos_y[139:108], acc_real_in[187:140], acc_imag_in[235:188], zero pad
  input  logic [239:0] s_axis_tdata_i,
  // action[1:0]
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // acc_real_out[47:0], acc_imag_out[95:48]
  output logic [95:0]  m_axis_tdata_o,
  // hit[0]
  output logic         m_axis_tuser_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);

  logic        en;
  logic [12:0] entry_count_q;
  logic [31:0] inv_step_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= 13'd4096;
      inv_step_q    <= 32'd65536;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ENTRY_COUNT: entry_count_q <= cfg_data_i[12:0];
        CFG_INV_STEP:    inv_step_q    <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  // Input unpacking and squares.
  meta_t       in_meta;
  logic [31:0] pos_x, pos_y, abs_x, abs_y;

  assign in_meta.action      = action_e'(s_axis_tuser_i);
  assign in_meta.entry_index = s_axis_tdata_i[11:0];
  assign in_meta.load_real   = s_axis_tdata_i[43:12];
  assign in_meta.load_imag   = s_axis_tdata_i[75:44];
  assign in_meta.acc_re      = s_axis_tdata_i[187:140];
  assign in_meta.acc_im      = s_axis_tdata_i[235:188];
  assign pos_x = s_axis_tdata_i[107:76];
  assign pos_y = s_axis_tdata_i[139:108];
  assign abs_x = pos_x[31] ? (~pos_x + 32'd1) : pos_x;
  assign abs_y = pos_y[31] ? (~pos_y + 32'd1) : pos_y;

  logic        s1_valid_q, s2_valid_q;
  logic [63:0] s1_x2_q, s1_y2_q, s2_r2_q;
  meta_t       s1_meta_q, s2_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= s_axis_tvalid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_x2_q   <= abs_x * abs_x;
      s1_y2_q   <= abs_y * abs_y;
      s1_meta_q <= in_meta;
      s2_r2_q   <= s1_x2_q + s1_y2_q;
      s2_meta_q <= s1_meta_q;
    end
  end

  // Square root.
  logic        sq_valid;
  logic [31:0] sq_rad;
  meta_t       sq_meta;

  rtia_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s2_valid_q),
    .r2_i    (s2_r2_q),
    .meta_i  (s2_meta_q),
    .valid_o (sq_valid),
    .rad_o   (sq_rad),
    .meta_o  (sq_meta)
  );

  // Scale by the inverse step.
  logic        mul_valid_q;
  logic [63:0] mul_prod_q;
  meta_t       mul_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mul_valid_q <= 1'b0;
    else if (en) mul_valid_q <= sq_valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mul_prod_q <= sq_rad * inv_step_q;
      mul_meta_q <= sq_meta;
    end
  end

  // Table stage: index check, loads and the two reads.
  logic [31:0] idx;
  logic [32:0] idx_next;
  logic        is_lookup, in_range, do_load;
  side_t       lk_side_d;

  assign idx       = mul_prod_q[63:32];
  assign idx_next  = {1'b0, idx} + 33'd1;
  assign is_lookup = (mul_meta_q.action == ACT_ADD) || (mul_meta_q.action == ACT_SUB);
  assign in_range  = (idx_next < 33'(entry_count_q)) && (idx_next < 33'(TABLE_DEPTH));
  assign do_load   = en && mul_valid_q && (mul_meta_q.action == ACT_LOAD)
                     && (32'(mul_meta_q.entry_index) < 32'(TABLE_DEPTH));

  assign lk_side_d.hit    = (mul_meta_q.action == ACT_LOAD) || (is_lookup && in_range);
  assign lk_side_d.apply  = is_lookup && in_range;
  assign lk_side_d.sub    = (mul_meta_q.action == ACT_SUB);
  assign lk_side_d.acc_re = mul_meta_q.acc_re;
  assign lk_side_d.acc_im = mul_meta_q.acc_im;

  logic        lk_valid_q;
  side_t       lk_side_q;
  logic [15:0] lk_frac_q;
  logic [63:0] rd_lo, rd_hi, wr_data;
  logic [AddrW-1:0] wr_addr;

  assign wr_data = {mul_meta_q.load_imag, mul_meta_q.load_real};
  assign wr_addr = AddrW'(mul_meta_q.entry_index);

  // Two copies of the table give the two read ports for index and index+1.
  rtia_ram #(.Width(64), .Depth(TABLE_DEPTH)) u_ram_lo (
    .clk_i   (clk_i),
    .we_i    (do_load),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (en),
    .raddr_i (idx[AddrW-1:0]),
    .rdata_o (rd_lo)
  );

  rtia_ram #(.Width(64), .Depth(TABLE_DEPTH)) u_ram_hi (
    .clk_i   (clk_i),
    .we_i    (do_load),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (en),
    .raddr_i (idx_next[AddrW-1:0]),
    .rdata_o (rd_hi)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) lk_valid_q <= 1'b0;
    else if (en) lk_valid_q <= mul_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lk_side_q <= lk_side_d;
      lk_frac_q <= mul_prod_q[31:16];
    end
  end

  // Interpolation and accumulation.
  logic        fin_valid, fin_hit;
  logic [47:0] fin_re, fin_im;

  rtia_lerp u_lerp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (lk_valid_q),
    .lo_i     (rd_lo),
    .hi_i     (rd_hi),
    .frac_i   (lk_frac_q),
    .side_i   (lk_side_q),
    .valid_o  (fin_valid),
    .acc_re_o (fin_re),
    .acc_im_o (fin_im),
    .hit_o    (fin_hit)
  );

  // Output register and skid entry.
  logic        out_valid_q, skid_valid_q;
  logic        out_valid_d, skid_valid_d;
  logic [96:0] out_q, skid_q;
  logic        out_free;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign en       = !skid_valid_q;
  assign s_axis_tready_o = en;

  always_comb begin
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (out_free) begin
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end
    end else if (fin_valid) begin
      if (out_free) out_valid_d  = 1'b1;
      else          skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_free) out_q <= skid_q;
    end else if (fin_valid) begin
      if (out_free) out_q  <= {fin_hit, fin_im, fin_re};
      else          skid_q <= {fin_hit, fin_im, fin_re};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q[95:0];
  assign m_axis_tuser_o  = out_q[96];

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds a result while the output register is empty");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !m_axis_tready_i) |=> (skid_valid_q && $stable(skid_q)))
    else $error("skid entry changed while the output was stalled");

  a_sqrt_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sq_valid && en) |=> mul_valid_q)
    else $error("radius result lost before the scale stage");

  a_frozen_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en && fin_valid) |=> fin_valid)
    else $error("pipeline result dropped during a stall");
`endif

endmodule
